@@ design/hrp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, constants and helper functions shared by the heading-rate PID blocks.
// ----------------------------------------------------------------------------
package hrp_pkg;

  // Width of one configuration register
  localparam int REG_W = 31;

  // Signed width that holds any truncated Q product and the sum of three of
  // them at the smallest fraction width (8 bits).
  localparam int ACC_W = 58;

  // Signed width of the heading error. It holds 2*pi at 24 fraction bits.
  localparam int ERR_W = 28;

  // Pi scaled by 2^24, rounded to nearest
  localparam longint PI_Q24 = 64'sd52707179;

  localparam logic signed [ACC_W-1:0] ACC_I32_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] ACC_I32_MIN = ACC_W'(-64'sd2147483648);

  // Register reset values
  localparam logic [REG_W-1:0] RST_PROP_GAIN   = 31'd65536;
  localparam logic [REG_W-1:0] RST_INTEG_GAIN  = 31'd0;
  localparam logic [REG_W-1:0] RST_DERIV_GAIN  = 31'd0;
  localparam logic [REG_W-1:0] RST_MAX_RATE    = 31'd65536;
  localparam logic [REG_W-1:0] RST_MIN_RATE    = 31'd0;
  localparam logic [REG_W-1:0] RST_MAX_STEP    = 31'd32768;
  localparam logic [REG_W-1:0] RST_LOOP_PERIOD = 31'd3277;
  localparam logic [REG_W-1:0] RST_LOOP_RATE   = 31'd1310720;

  typedef enum logic [2:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_MAX_RATE,
    REG_MIN_RATE,
    REG_MAX_STEP,
    REG_LOOP_PERIOD,
    REG_LOOP_RATE
  } cfg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] prop_gain;
    logic [REG_W-1:0] integ_gain;
    logic [REG_W-1:0] deriv_gain;
    logic [REG_W-1:0] max_rate;
    logic [REG_W-1:0] min_rate;
    logic [REG_W-1:0] max_step;
    logic [REG_W-1:0] loop_period;
    logic [REG_W-1:0] loop_rate;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_MUL_RATE,
    S_TRATE,
    S_RERR,
    S_MUL_INTEG,
    S_MUL_DERIV,
    S_MUL_KI,
    S_MUL_KD,
    S_MUL_KP,
    S_SUM,
    S_INCR,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_WRAP,
    STEP_MUL_RATE,
    STEP_TRATE,
    STEP_RERR,
    STEP_MUL_INTEG,
    STEP_MUL_DERIV,
    STEP_MUL_KI,
    STEP_MUL_KD,
    STEP_MUL_KP,
    STEP_SUM,
    STEP_INCR
  } dp_step_t;

  typedef struct packed {
    logic     load;
    dp_step_t step;
    logic     out_load;
  } dp_ctrl_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_I32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < ACC_I32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_mag(input logic signed [ACC_W-1:0] v,
                                                       input logic [REG_W-1:0] lim);
    logic signed [ACC_W-1:0] lim_s;
    logic signed [ACC_W-1:0] r;
    lim_s = {{(ACC_W-REG_W){1'b0}}, lim};
    if (v > lim_s) begin
      r = lim_s;
    end else if (v < -lim_s) begin
      r = -lim_s;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ design/hrp_cfg.sv @@
// ----------------------------------------------------------------------------
// hrp_cfg
// Configuration register file: eight 31-bit registers, write only.
// ----------------------------------------------------------------------------
module hrp_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [2:0]                cfg_index,
  input  logic [hrp_pkg::REG_W-1:0] cfg_wdata,
  output hrp_pkg::cfg_t             cfg
);
  import hrp_pkg::*;

  cfg_t regs_r;
  cfg_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_PROP_GAIN:   regs_nxt.prop_gain   = cfg_wdata;
        REG_INTEG_GAIN:  regs_nxt.integ_gain  = cfg_wdata;
        REG_DERIV_GAIN:  regs_nxt.deriv_gain  = cfg_wdata;
        REG_MAX_RATE:    regs_nxt.max_rate    = cfg_wdata;
        REG_MIN_RATE:    regs_nxt.min_rate    = cfg_wdata;
        REG_MAX_STEP:    regs_nxt.max_step    = cfg_wdata;
        REG_LOOP_PERIOD: regs_nxt.loop_period = cfg_wdata;
        REG_LOOP_RATE:   regs_nxt.loop_rate   = cfg_wdata;
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.prop_gain   <= RST_PROP_GAIN;
      regs_r.integ_gain  <= RST_INTEG_GAIN;
      regs_r.deriv_gain  <= RST_DERIV_GAIN;
      regs_r.max_rate    <= RST_MAX_RATE;
      regs_r.min_rate    <= RST_MIN_RATE;
      regs_r.max_step    <= RST_MAX_STEP;
      regs_r.loop_period <= RST_LOOP_PERIOD;
      regs_r.loop_rate   <= RST_LOOP_RATE;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg = regs_r;

endmodule

@@ design/hrp_ctrl.sv @@
// ----------------------------------------------------------------------------
// hrp_ctrl
// Sequencer for one control step: walks the datapath through the wrap, the
// six shared multiplies and the final clamps, and loads the output register.
// ----------------------------------------------------------------------------
module hrp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_stall,
  output hrp_pkg::dp_ctrl_t ctrl,
  input  hrp_pkg::dp_stat_t stat
);
  import hrp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    ctrl.load     = 1'b0;
    ctrl.step     = STEP_NONE;
    ctrl.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.load = 1'b1;
          // a clear goes straight to the output stage
          state_nxt = in_operation ? S_FIN : S_WRAP;
        end
      end
      S_WRAP: begin
        ctrl.step = STEP_WRAP;
        state_nxt = S_MUL_RATE;
      end
      S_MUL_RATE: begin
        ctrl.step = STEP_MUL_RATE;
        state_nxt = S_TRATE;
      end
      S_TRATE: begin
        ctrl.step = STEP_TRATE;
        state_nxt = S_RERR;
      end
      S_RERR: begin
        ctrl.step = STEP_RERR;
        state_nxt = S_MUL_INTEG;
      end
      S_MUL_INTEG: begin
        ctrl.step = STEP_MUL_INTEG;
        state_nxt = S_MUL_DERIV;
      end
      S_MUL_DERIV: begin
        ctrl.step = STEP_MUL_DERIV;
        state_nxt = S_MUL_KI;
      end
      S_MUL_KI: begin
        ctrl.step = STEP_MUL_KI;
        state_nxt = S_MUL_KD;
      end
      S_MUL_KD: begin
        ctrl.step = STEP_MUL_KD;
        state_nxt = S_MUL_KP;
      end
      S_MUL_KP: begin
        ctrl.step = STEP_MUL_KP;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        ctrl.step = STEP_SUM;
        state_nxt = S_INCR;
      end
      S_INCR: begin
        ctrl.step = STEP_INCR;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          ctrl.out_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_step_starts_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_operation |=> state_r == S_WRAP)
    else $error("control step did not start with the heading wrap");

  a_fin_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && !stat.out_busy |=> state_r == S_IDLE && !in_stall)
    else $error("sequencer did not return to idle after loading a result");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == S_IDLE)
    else $error("input taken outside idle");
`endif

endmodule

@@ design/hrp_dp.sv @@
// ----------------------------------------------------------------------------
// hrp_dp
// Datapath: input capture, heading wrap, one shared 33x31 multiplier with a
// registered product, PID state, clamps and the output register.
// ----------------------------------------------------------------------------
module hrp_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hrp_pkg::cfg_t       cfg,
  input  hrp_pkg::dp_ctrl_t   ctrl,
  output hrp_pkg::dp_stat_t   stat,
  input  logic                in_operation,
  input  logic signed [18:0]  in_target_heading,
  input  logic signed [18:0]  in_robot_heading,
  input  logic signed [31:0]  in_measured_rate,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [31:0]  out_rate_command
);
  import hrp_pkg::*;

  localparam int     SH   = 24 - FRAC_BITS;
  // pi at FRAC_BITS, rounded to nearest
  localparam longint PI_Q = (((PI_Q24 * 2) >>> SH) + 1) >>> 1;
  localparam logic signed [ERR_W-1:0] PI_E     = ERR_W'(PI_Q);
  localparam logic signed [ERR_W-1:0] TWO_PI_E = ERR_W'(2 * PI_Q);

  // captured transaction
  logic                     op_r;
  logic signed [18:0]       th_r;
  logic signed [18:0]       rh_r;
  logic signed [31:0]       meas_r;

  logic signed [ERR_W-1:0]  err_r;
  logic [63:0]              prod_r;
  logic                     pneg_r;
  logic signed [31:0]       trate_r;
  logic signed [31:0]       rerr_r;
  logic signed [31:0]       integ_r;
  logic signed [31:0]       prev_r;
  logic signed [31:0]       deriv_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [32:0]       sum_r;
  logic                     out_valid_r;
  logic signed [31:0]       out_rc_r;

  logic signed [ERR_W-1:0]  err_raw;
  logic signed [ERR_W-1:0]  err_w1;
  logic signed [ERR_W-1:0]  err_w2;
  logic signed [32:0]       diff;
  logic signed [33:0]       src;
  logic [32:0]              op_a;
  logic [REG_W-1:0]         op_b;
  logic [63:0]              p_sh;
  logic signed [ACC_W-1:0]  q_pos;
  logic signed [ACC_W-1:0]  qv;
  logic [32:0]              sum_mag;
  logic [REG_W-1:0]         lim1;
  logic [REG_W-1:0]         lim2;
  logic signed [31:0]       res;

  // heading error, wrapped once into plus or minus pi
  always_comb begin
    err_raw = ERR_W'(th_r) - ERR_W'(rh_r);
    err_w1  = (err_raw > PI_E) ? err_raw - TWO_PI_E : err_raw;
    err_w2  = (err_w1 < -PI_E) ? err_w1 + TWO_PI_E : err_w1;
  end

  assign diff = 33'(rerr_r) - 33'(prev_r);

  // multiplier operand select
  always_comb begin
    src  = '0;
    op_b = '0;
    unique case (ctrl.step)
      STEP_MUL_RATE: begin
        src  = 34'(err_r);
        op_b = cfg.loop_rate;
      end
      STEP_MUL_INTEG: begin
        src  = 34'(rerr_r);
        op_b = cfg.loop_period;
      end
      STEP_MUL_DERIV: begin
        src  = 34'(diff);
        op_b = cfg.loop_rate;
      end
      STEP_MUL_KI: begin
        src  = 34'(integ_r);
        op_b = cfg.integ_gain;
      end
      STEP_MUL_KD: begin
        src  = 34'(deriv_r);
        op_b = cfg.deriv_gain;
      end
      STEP_MUL_KP: begin
        src  = 34'(rerr_r);
        op_b = cfg.prop_gain;
      end
      default: begin
        src  = '0;
        op_b = '0;
      end
    endcase
    op_a = src[33] ? 33'(-src) : src[32:0];
  end

  // truncate the product magnitude toward zero, then restore the sign
  always_comb begin
    p_sh  = prod_r >> FRAC_BITS;
    q_pos = p_sh[ACC_W-1:0];
    qv    = pneg_r ? -q_pos : q_pos;
  end

  // final magnitude clamp, minimum raise and forced sign
  always_comb begin
    sum_mag = sum_r[32] ? 33'(-sum_r) : 33'(sum_r);
    lim1    = (sum_mag > 33'(cfg.max_rate)) ? cfg.max_rate : sum_mag[REG_W-1:0];
    lim2    = (lim1 < cfg.min_rate) ? cfg.min_rate : lim1;
    if (op_r) begin
      res = '0;
    end else if (trate_r[31]) begin
      res = -signed'({1'b0, lim2});
    end else begin
      res = signed'({1'b0, lim2});
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r   <= in_operation;
      th_r   <= in_target_heading;
      rh_r   <= in_robot_heading;
      meas_r <= in_measured_rate;
    end
    prod_r <= {31'b0, op_a} * {33'b0, op_b};
    pneg_r <= src[33];
    case (ctrl.step)
      STEP_WRAP:      err_r   <= err_w2;
      STEP_TRATE:     trate_r <= 32'(clamp_mag(qv, cfg.max_rate));
      STEP_RERR:      rerr_r  <= sat32(ACC_W'(trate_r) - ACC_W'(meas_r));
      STEP_MUL_KI:    deriv_r <= sat32(qv);
      STEP_MUL_KD:    acc_r   <= qv;
      STEP_MUL_KP:    acc_r   <= acc_r + qv;
      STEP_SUM:       acc_r   <= acc_r + qv;
      STEP_INCR:      sum_r   <= 33'(meas_r) + 33'(clamp_mag(acc_r, cfg.max_step));
      default: begin
      end
    endcase
  end

  // PID state: integral and last rate error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else if (ctrl.load && in_operation) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else if (ctrl.step == STEP_MUL_DERIV) begin
      integ_r <= sat32(ACC_W'(integ_r) + qv);
      prev_r  <= rerr_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_rc_r <= res;
    end
  end

  assign stat.out_busy    = out_valid_r && out_stall;
  assign out_valid        = out_valid_r;
  assign out_rate_command = out_rc_r;

`ifndef SYNTHESIS
  a_clear_zeroes_state: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load && in_operation |=> integ_r == 32'sd0 && prev_r == 32'sd0)
    else $error("clear left PID state nonzero");

  a_trate_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step == STEP_TRATE |=>
      trate_r <= $signed({1'b0, $past(cfg.max_rate)}) &&
      trate_r >= -$signed({1'b0, $past(cfg.max_rate)}))
    else $error("target rate outside the max_rate limit");

  a_clear_outputs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load && op_r |=> out_valid && out_rate_command == 32'sd0)
    else $error("clear produced a nonzero rate command");
`endif

endmodule

@@ design/heading_rate_pid_unit.sv @@
// ----------------------------------------------------------------------------
// heading_rate_pid_unit
// Heading-rate PID regulator with rate, increment and output clamps.
// ----------------------------------------------------------------------------
//
//  channel | ports                                           | direction
//  --------+-------------------------------------------------+----------
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata                 | in
//  in      | in_valid/in_stall, in_operation, in_*_heading,  | in
//          | in_measured_rate                                |
//  out     | out_valid/out_stall, out_rate_command           | out
//
// A control step runs from acceptance through the wrap, then six products on one
// shared 33x31 multiplier in sequence, to the output stage; no new transaction is
// taken until the sequencer is back in idle. A clear goes straight to the output
// stage. Reset returns the registers to their defaults and zeroes the integral
// and the last error. A stalled result stays in the output register; the next
// transaction is taken meanwhile and waits in its last stage only if it
// finishes before the result is taken.
// ----------------------------------------------------------------------------
module heading_rate_pid_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [2:0]                cfg_index,
  input  logic [hrp_pkg::REG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic signed [18:0]        in_target_heading,
  input  logic signed [18:0]        in_robot_heading,
  input  logic signed [31:0]        in_measured_rate,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        out_rate_command
);
  import hrp_pkg::*;

  cfg_t     cfg;
  dp_ctrl_t ctrl;
  dp_stat_t stat;

  hrp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hrp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .ctrl         (ctrl),
    .stat         (stat)
  );

  hrp_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .ctrl              (ctrl),
    .stat              (stat),
    .in_operation      (in_operation),
    .in_target_heading (in_target_heading),
    .in_robot_heading  (in_robot_heading),
    .in_measured_rate  (in_measured_rate),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_rate_command  (out_rate_command)
  );

endmodule
